### design/hrp_pkg.sv
// Shared types, constants and character tables of the reply header parser.
`timescale 1ns / 1ps
package hrp_pkg;

  localparam int LINE_LIMIT = 1024;
  localparam int COL_W      = 11;
  localparam int NTAGS      = 4;

  localparam logic [1:0] TAG_LOC    = 2'd0;
  localparam logic [1:0] TAG_CLEN   = 2'd1;
  localparam logic [1:0] TAG_CRANGE = 2'd2;
  localparam logic [1:0] TAG_TENC   = 2'd3;

  localparam logic [4:0] TAG_LEN [NTAGS] = '{5'd8, 5'd14, 5'd13, 5'd17};

  localparam logic [8*8-1:0]  LOC_TXT    = "Location";
  localparam logic [14*8-1:0] CLEN_TXT   = "Content-Length";
  localparam logic [13*8-1:0] CRANGE_TXT = "Content-Range";
  localparam logic [17*8-1:0] TENC_TXT   = "Transfer-Encoding";
  localparam logic [7*8-1:0]  CHUNK_TXT  = "chunked";
  localparam logic [3:0]      CHUNK_LEN  = 4'd7;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [9:0]  CODE_MAX     = 10'd999;
  localparam logic [9:0]  CODE_ERR_LO  = 10'd400;
  localparam logic [9:0]  CODE_ERR_HI  = 10'd600;
  localparam logic [9:0]  CODE_MOVED   = 10'd301;
  localparam logic [9:0]  CODE_FOUND   = 10'd302;
  localparam logic [9:0]  CODE_SEEOTH  = 10'd303;
  localparam logic [3:0]  VM_FAIL      = 4'd15;
  localparam logic [3:0]  VM_NEG       = 4'd1;

  typedef enum logic [1:0] {
    PH_PARSING  = 2'd0,
    PH_DONE     = 2'd1,
    PH_ERR_CODE = 2'd2,
    PH_BAD_LOC  = 2'd3
  } hrp_phase_t;

  typedef enum logic [2:0] {
    FP_LEAD = 3'd0,
    FP_GAP  = 3'd1,
    FP_MID  = 3'd2,
    FP_TAIL = 3'd3,
    FP_DONE = 3'd4
  } hrp_part_t;

  typedef struct packed {
    logic redirect;
    logic stream;
    logic chunked;
  } hrp_flags_t;

  typedef struct packed {
    hrp_phase_t       phase;
    logic             first_line;
    logic [COL_W-1:0] column;
    logic             pending_cr;
    hrp_part_t        field_part;
    logic [NTAGS-1:0] tag_cand;
    logic [3:0]       value_match;
    logic [31:0]      value_accum;
    logic [9:0]       code;
    logic [31:0]      length;
    hrp_flags_t       flags;
  } hrp_state_t;

  localparam hrp_state_t STATE_RESET = '{
    phase:       PH_PARSING,
    first_line:  1'b1,
    column:      '0,
    pending_cr:  1'b0,
    field_part:  FP_LEAD,
    tag_cand:    '1,
    value_match: '0,
    value_accum: '0,
    code:        '0,
    length:      '0,
    flags:       '{redirect: 1'b0, stream: 1'b1, chunked: 1'b0}
  };

endpackage

### design/hrp_if.sv
// Valid/ready channel interfaces for header bytes and parse status.
`timescale 1ns / 1ps
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       start_reply;

  modport source (output valid, output rx_byte, output start_reply, input ready);
  modport sink   (input valid, input rx_byte, input start_reply, output ready);
endinterface

interface hrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  header_state;
  logic [9:0]  status_code;
  logic [31:0] content_length;
  logic        is_chunked;
  logic        is_stream;
  logic        redirect;

  modport source (output valid, output header_state, output status_code,
                  output content_length, output is_chunked, output is_stream,
                  output redirect, input ready);
  modport sink   (input valid, input header_state, input status_code,
                  input content_length, input is_chunked, input is_stream,
                  input redirect, output ready);
endinterface

### design/hrp_step.sv
// Next parse state for one header byte.
`timescale 1ns / 1ps
module hrp_step (
  input  hrp_pkg::hrp_state_t cur,
  input  logic [7:0]          rx_byte,
  input  logic                start_reply,
  output hrp_pkg::hrp_state_t nxt
);
  import hrp_pkg::*;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic [31:0] dig_val(input logic [7:0] b);
    return {24'd0, b - CH_ZERO};
  endfunction

  function automatic logic [7:0] tag_char(input logic [1:0] tag, input logic [4:0] p);
    logic [4:0] k;
    logic [7:0] c;
    c = 8'h00;
    k = 5'd0;
    case (tag)
      TAG_LOC: begin
        k = TAG_LEN[0] - 5'd1 - p;
        c = LOC_TXT[8*k +: 8];
      end
      TAG_CLEN: begin
        k = TAG_LEN[1] - 5'd1 - p;
        c = CLEN_TXT[8*k +: 8];
      end
      TAG_CRANGE: begin
        k = TAG_LEN[2] - 5'd1 - p;
        c = CRANGE_TXT[8*k +: 8];
      end
      TAG_TENC: begin
        k = TAG_LEN[3] - 5'd1 - p;
        c = TENC_TXT[8*k +: 8];
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic hrp_state_t value_byte(input hrp_state_t s, input logic [7:0] b);
    hrp_state_t r;
    logic [2:0] k;
    r = s;
    k = 3'd0;
    if (s.tag_cand[TAG_CLEN]) begin
      if (s.value_match == 4'd0 && is_dig(b)) begin
        r.value_accum = (s.value_accum << 3) + (s.value_accum << 1) + dig_val(b);
      end else begin
        r.value_match = 4'd1;
      end
    end else if (s.tag_cand[TAG_TENC]) begin
      r.value_match = VM_FAIL;
      if (s.value_match < CHUNK_LEN) begin
        k = 3'(CHUNK_LEN - 4'd1 - s.value_match);
        if (b == CHUNK_TXT[8*k +: 8]) begin
          r.value_match = s.value_match + 4'd1;
        end
      end
    end
    return r;
  endfunction

  function automatic hrp_state_t first_byte(input hrp_state_t s, input logic [7:0] b);
    hrp_state_t  r;
    logic [31:0] acc;
    r = s;
    acc = '0;
    case (s.field_part)
      FP_LEAD: if (is_ws(b)) r.field_part = FP_GAP;
      FP_GAP: begin
        if (!is_ws(b)) begin
          if (b == CH_PLUS || b == CH_MINUS) begin
            r.value_match = (b == CH_MINUS) ? VM_NEG : 4'd0;
            r.field_part  = FP_MID;
          end else if (is_dig(b)) begin
            r.value_accum = dig_val(b);
            r.field_part  = FP_TAIL;
          end else begin
            r.field_part = FP_DONE;
          end
        end
      end
      FP_MID: begin
        if (is_dig(b)) begin
          r.value_accum = dig_val(b);
          r.field_part  = FP_TAIL;
        end else begin
          r.field_part = FP_DONE;
        end
      end
      FP_TAIL: begin
        if (is_dig(b)) begin
          acc = (s.value_accum << 3) + (s.value_accum << 1) + dig_val(b);
          r.value_accum = (acc > {22'd0, CODE_MAX}) ? {22'd0, CODE_MAX} : acc;
        end else begin
          r.field_part = FP_DONE;
        end
      end
      default: r = s;
    endcase
    return r;
  endfunction

  function automatic hrp_state_t later_byte(input hrp_state_t s, input logic [7:0] b,
                                            input logic [COL_W-1:0] pos);
    hrp_state_t       r;
    logic [NTAGS-1:0] hit;
    logic             ok;
    r = s;
    hit = '0;
    ok = 1'b0;
    case (s.field_part)
      FP_LEAD: begin
        if (b == CH_COLON) begin
          for (int i = 0; i < NTAGS; i++) begin
            if (s.tag_cand[i] && pos == {{(COL_W-5){1'b0}}, TAG_LEN[i]}) begin
              hit = NTAGS'(1) << i;
            end
          end
          r.tag_cand   = hit;
          r.field_part = (hit != '0) ? FP_GAP : FP_TAIL;
        end else begin
          for (int i = 0; i < NTAGS; i++) begin
            ok = 1'b0;
            if (pos < {{(COL_W-5){1'b0}}, TAG_LEN[i]}) begin
              ok = (b == tag_char(2'(i), pos[4:0]));
            end
            if (!ok) r.tag_cand[i] = 1'b0;
          end
        end
      end
      FP_GAP: begin
        if (!is_ws(b)) begin
          r.field_part = FP_MID;
          r = value_byte(r, b);
        end
      end
      FP_MID: r = value_byte(s, b);
      default: r = s;
    endcase
    return r;
  endfunction

  function automatic hrp_state_t feed(input hrp_state_t s, input logic [7:0] b,
                                      input logic [COL_W-1:0] pos);
    return s.first_line ? first_byte(s, b) : later_byte(s, b, pos);
  endfunction

  function automatic hrp_state_t new_line(input hrp_state_t s);
    hrp_state_t r;
    r = s;
    r.column      = '0;
    r.pending_cr  = 1'b0;
    r.field_part  = FP_LEAD;
    r.tag_cand    = '1;
    r.value_match = '0;
    r.value_accum = '0;
    return r;
  endfunction

  function automatic hrp_state_t end_line(input hrp_state_t s);
    hrp_state_t       r;
    logic [COL_W-1:0] stored;
    logic [9:0]       code;
    r = s;
    code = '0;
    stored = s.column - {{(COL_W-1){1'b0}}, s.pending_cr};
    if (stored == '0) begin
      r.phase = PH_DONE;
    end else if (s.first_line) begin
      if (!s.value_match[0]) begin
        code = (s.value_accum > {22'd0, CODE_MAX}) ? CODE_MAX : s.value_accum[9:0];
      end
      r.code = code;
      if (code >= CODE_ERR_LO && code < CODE_ERR_HI) r.phase = PH_ERR_CODE;
      r.first_line = 1'b0;
    end else if (s.field_part == FP_GAP || s.field_part == FP_MID) begin
      if (s.tag_cand[TAG_LOC]) begin
        if (s.code == CODE_MOVED || s.code == CODE_FOUND || s.code == CODE_SEEOTH) begin
          r.flags.redirect = 1'b1;
        end else begin
          r.phase = PH_BAD_LOC;
        end
      end else if (s.tag_cand[TAG_CLEN]) begin
        r.length = s.value_accum;
      end else if (s.tag_cand[TAG_CRANGE]) begin
        r.flags.stream = 1'b0;
      end else if (s.tag_cand[TAG_TENC]) begin
        if (s.value_match == CHUNK_LEN) begin
          r.flags.stream  = 1'b1;
          r.flags.chunked = 1'b1;
        end
      end
    end
    return new_line(r);
  endfunction

  hrp_state_t       base;
  hrp_state_t       work;
  logic [COL_W-1:0] pos;

  always_comb begin
    base = start_reply ? STATE_RESET : cur;
    work = base;
    pos  = base.column;
    if (base.phase == PH_PARSING) begin
      if (rx_byte == CH_LF) begin
        work = end_line(base);
      end else if (pos < COL_W'(LINE_LIMIT - 1)) begin
        if (base.pending_cr) begin
          work.pending_cr = 1'b0;
          work = feed(work, CH_CR, pos - COL_W'(1));
        end
        if (rx_byte == CH_CR) begin
          work.pending_cr = 1'b1;
        end else begin
          work = feed(work, rx_byte, pos);
        end
        work.column = pos + COL_W'(1);
      end
    end
  end

  assign nxt = work;

endmodule

### design/http_response_header_parser_core.sv
// Byte-serial reply header parser: state registers, result handshake and checks.
//
// Usage:
//   in_ch  carries one header byte per transfer (rx_byte) and start_reply, which
//          clears all parse state before that byte is taken.
//   out_ch returns one status item per accepted byte: header_state, status_code,
//          content_length, is_chunked, is_stream and redirect as they stand after
//          that byte.
//   The result is valid in the cycle after the input transfer. One byte is taken
//   every cycle unless out_ch stalls; the whole per-byte update is a single pass
//   through the next-state logic into the state registers, which also drive the
//   result. When out_ch stalls, the finished result holds and in_ch accepts
//   exactly when the result register is empty or being drained in the same cycle.
//   Reset (rst_n low, synchronous) empties the result register and returns the
//   parse state to its start: parsing, first line, stream flag set.
//   After the header completes or fails, bytes are taken but change nothing
//   until start_reply.
`timescale 1ns / 1ps
module http_response_header_parser_core (
  input logic          clk,
  input logic          rst_n,
  hrp_in_if.sink       in_ch,
  hrp_out_if.source    out_ch
);
  import hrp_pkg::*;

  hrp_state_t state_r;
  hrp_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       in_xfer;

  hrp_step u_step (
    .cur         (state_r),
    .rx_byte     (in_ch.rx_byte),
    .start_reply (in_ch.start_reply),
    .nxt         (state_nxt)
  );

  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign out_valid_nxt = in_xfer || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) state_r <= state_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.header_state   = state_r.phase;
  assign out_ch.status_code    = state_r.code;
  assign out_ch.content_length = state_r.length;
  assign out_ch.is_chunked     = state_r.flags.chunked;
  assign out_ch.is_stream      = state_r.flags.stream;
  assign out_ch.redirect       = state_r.flags.redirect;

`ifndef ASSERT_OFF
  a_start_parses: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_ch.start_reply && in_ch.rx_byte != CH_LF
    |=> out_ch.header_state == PH_PARSING)
    else $error("start of reply did not restart parsing");

  a_end_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_ch.start_reply && state_r.phase != PH_PARSING
    |=> state_r.phase == $past(state_r.phase))
    else $error("finished header state changed without start of reply");

  a_redirect_code: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.flags.redirect
    |-> (state_r.code == CODE_MOVED || state_r.code == CODE_FOUND ||
         state_r.code == CODE_SEEOTH))
    else $error("redirect flag set with a non-redirect status code");

  a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.column <= COL_W'(LINE_LIMIT - 1))
    else $error("line column ran past the line limit");

  a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> $stable(state_r))
    else $error("parse state moved without an input transfer");
`endif

endmodule

### test/tb_http_response_header_parser_core.sv
// Self-checking bench for the reply header parser: byte-level prediction, random stalls.
`timescale 1ns / 1ps
module tb_http_response_header_parser_core;
  import hrp_pkg::*;

  localparam int         CYCLE_LIMIT = 500000;
  localparam logic [3:0] LEN_STOP    = 4'd1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start;
    logic       drain;
  } hdr_byte_t;

  typedef struct packed {
    hrp_phase_t  state;
    logic [9:0]  code;
    logic [31:0] length;
    logic        chunked;
    logic        stream;
    logic        redirect;
  } hdr_status_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic       drv_valid = 1'b0;
  logic [7:0] drv_rx    = '0;
  logic       drv_start = 1'b0;
  logic       drv_ready = 1'b0;

  hrp_in_if  in_ch ();
  hrp_out_if out_ch ();

  assign in_ch.valid       = drv_valid;
  assign in_ch.rx_byte     = drv_rx;
  assign in_ch.start_reply = drv_start;
  assign out_ch.ready      = drv_ready;

  http_response_header_parser_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  string tag_names [NTAGS] = '{"Location", "Content-Length", "Content-Range", "Transfer-Encoding"};
  string chunk_word        = "chunked";
  int    code_pool [12]    = '{200, 204, 206, 301, 302, 303, 304, 400, 404, 500, 599, 600};

  hdr_byte_t   byte_q [$];
  hdr_status_t status_due_q [$];

  bit reply_open = 1'b0;
  bit drain_open = 1'b0;
  bit calm       = 1'b0;
  int in_gap     = 0;
  int out_gap    = 0;
  int errors     = 0;
  int results    = 0;
  int cycle_count = 0;

  hrp_phase_t  hdr_phase;
  logic        hdr_first_line;
  logic [10:0] hdr_column;
  logic        hdr_cr_held;
  hrp_part_t   hdr_part;
  logic [3:0]  hdr_tags;
  logic [3:0]  hdr_vmatch;
  logic [31:0] hdr_accum;
  logic [9:0]  hdr_code;
  logic [31:0] hdr_length;
  hrp_flags_t  hdr_flags;

  function automatic bit is_space(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  task automatic report(input string what);
    $display("mismatch at status %0d: %s", results, what);
    errors++;
  endtask

  task automatic reset_line();
    hdr_column  = '0;
    hdr_cr_held = 1'b0;
    hdr_part    = FP_LEAD;
    hdr_tags    = '1;
    hdr_vmatch  = '0;
    hdr_accum   = '0;
  endtask

  task automatic reset_parse();
    hdr_phase      = PH_PARSING;
    hdr_first_line = 1'b1;
    reset_line();
    hdr_code   = '0;
    hdr_length = '0;
    hdr_flags  = '{redirect: 1'b0, stream: 1'b1, chunked: 1'b0};
  endtask

  task automatic value_char(input logic [7:0] b);
    if (hdr_tags[TAG_CLEN]) begin
      if (hdr_vmatch == '0 && is_digit(b)) hdr_accum = hdr_accum * 32'd10 + 32'(b - CH_ZERO);
      else hdr_vmatch = LEN_STOP;
    end else if (hdr_tags[TAG_TENC]) begin
      if (hdr_vmatch < CHUNK_LEN && b == chunk_word[hdr_vmatch]) hdr_vmatch++;
      else hdr_vmatch = VM_FAIL;
    end
  endtask

  task automatic feed_char(input logic [7:0] b, input int pos);
    logic [3:0] hit;
    if (hdr_first_line) begin
      case (hdr_part)
        FP_LEAD: if (is_space(b)) hdr_part = FP_GAP;
        FP_GAP: begin
          if (!is_space(b)) begin
            if (b == CH_PLUS || b == CH_MINUS) begin
              hdr_vmatch = (b == CH_MINUS) ? VM_NEG : 4'd0;
              hdr_part   = FP_MID;
            end else if (is_digit(b)) begin
              hdr_accum = 32'(b - CH_ZERO);
              hdr_part  = FP_TAIL;
            end else begin
              hdr_part = FP_DONE;
            end
          end
        end
        FP_MID: begin
          if (is_digit(b)) begin
            hdr_accum = 32'(b - CH_ZERO);
            hdr_part  = FP_TAIL;
          end else begin
            hdr_part = FP_DONE;
          end
        end
        FP_TAIL: begin
          if (is_digit(b)) begin
            hdr_accum = hdr_accum * 32'd10 + 32'(b - CH_ZERO);
            if (hdr_accum > 32'(CODE_MAX)) hdr_accum = 32'(CODE_MAX);
          end else begin
            hdr_part = FP_DONE;
          end
        end
        default: ;
      endcase
    end else begin
      case (hdr_part)
        FP_LEAD: begin
          if (b == CH_COLON) begin
            hit = '0;
            for (int i = 0; i < NTAGS; i++)
              if (hdr_tags[i] && tag_names[i].len() == pos) hit = 4'b0001 << i;
            hdr_tags = hit;
            hdr_part = (hit != '0) ? FP_GAP : FP_TAIL;
          end else begin
            for (int i = 0; i < NTAGS; i++)
              if (pos >= tag_names[i].len() || b != tag_names[i][pos]) hdr_tags[i] = 1'b0;
          end
        end
        FP_GAP: begin
          if (!is_space(b)) begin
            hdr_part = FP_MID;
            value_char(b);
          end
        end
        FP_MID: value_char(b);
        default: ;
      endcase
    end
  endtask

  task automatic close_line();
    int stored;
    stored = int'(hdr_column) - int'(hdr_cr_held);
    if (stored == 0) begin
      hdr_phase = PH_DONE;
    end else if (hdr_first_line) begin
      if (hdr_vmatch[0]) hdr_code = '0;
      else if (hdr_accum > 32'(CODE_MAX)) hdr_code = CODE_MAX;
      else hdr_code = hdr_accum[9:0];
      if (hdr_code >= CODE_ERR_LO && hdr_code < CODE_ERR_HI) hdr_phase = PH_ERR_CODE;
      hdr_first_line = 1'b0;
    end else if (hdr_part == FP_GAP || hdr_part == FP_MID) begin
      if (hdr_tags[TAG_LOC]) begin
        if (hdr_code == CODE_MOVED || hdr_code == CODE_FOUND || hdr_code == CODE_SEEOTH)
          hdr_flags.redirect = 1'b1;
        else
          hdr_phase = PH_BAD_LOC;
      end else if (hdr_tags[TAG_CLEN]) begin
        hdr_length = hdr_accum;
      end else if (hdr_tags[TAG_CRANGE]) begin
        hdr_flags.stream = 1'b0;
      end else if (hdr_tags[TAG_TENC]) begin
        if (hdr_vmatch == CHUNK_LEN) begin
          hdr_flags.chunked = 1'b1;
          hdr_flags.stream  = 1'b1;
        end
      end
    end
    reset_line();
  endtask

  task automatic parse_header_byte(input logic [7:0] b, input logic restart);
    int pos;
    if (restart) reset_parse();
    if (hdr_phase == PH_PARSING) begin
      if (b == CH_LF) begin
        close_line();
      end else if (int'(hdr_column) < LINE_LIMIT - 1) begin
        pos = int'(hdr_column);
        if (hdr_cr_held) begin
          hdr_cr_held = 1'b0;
          feed_char(CH_CR, pos - 1);
        end
        if (b == CH_CR) hdr_cr_held = 1'b1;
        else feed_char(b, pos);
        hdr_column = 11'(pos + 1);
      end
    end
    status_due_q.push_back(hdr_status_t'{state: hdr_phase, code: hdr_code,
                                         length: hdr_length, chunked: hdr_flags.chunked,
                                         stream: hdr_flags.stream,
                                         redirect: hdr_flags.redirect});
  endtask

  task automatic put(input logic [7:0] b);
    byte_q.push_back(hdr_byte_t'{rx_byte: b, start: reply_open, drain: drain_open});
    reply_open = 1'b0;
    drain_open = 1'b0;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_line(input string s);
    put_text(s);
    put(CH_CR);
    put(CH_LF);
  endtask

  task automatic put_eol();
    if ($urandom_range(0, 3) == 0) begin
      put(CH_LF);
    end else begin
      put(CH_CR);
      put(CH_LF);
    end
  endtask

  task automatic put_gap(input int most);
    repeat ($urandom_range(0, most)) put(($urandom_range(0, 1) == 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic put_mutated(input string s);
    int pos;
    pos = $urandom_range(0, s.len() - 1);
    for (int i = 0; i < s.len(); i++)
      put((i == pos) ? 8'($urandom_range(0, 255)) : s[i]);
  endtask

  task automatic begin_reply();
    reply_open = 1'b1;
    drain_open = ($urandom_range(0, 7) == 0);
  endtask

  // driver: present the head of the byte queue, predict on each transfer
  always @(posedge clk) begin
    if (rst_n) begin
      calm <= (byte_q.size() < 120);
      if (drv_valid && in_ch.ready) begin
        parse_header_byte(drv_rx, drv_start);
        void'(byte_q.pop_front());
      end
      if (!drv_valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          drv_valid <= 1'b0;
        end else if (byte_q.size() == 0 || (byte_q[0].drain && status_due_q.size() != 0)) begin
          drv_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          in_gap = $urandom_range(0, 9);
          drv_valid <= 1'b0;
        end else begin
          drv_valid <= 1'b1;
          drv_rx    <= byte_q[0].rx_byte;
          drv_start <= byte_q[0].start;
        end
      end
    end
  end

  // monitor: compare each status transfer with the oldest prediction
  always @(posedge clk) begin
    hdr_status_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (status_due_q.size() == 0) begin
          report("status transfer with no byte outstanding");
        end else begin
          want = status_due_q.pop_front();
          if (out_ch.header_state !== want.state)
            report($sformatf("header_state %0d, want %0d", out_ch.header_state, want.state));
          if (out_ch.status_code !== want.code)
            report($sformatf("status_code %0d, want %0d", out_ch.status_code, want.code));
          if (out_ch.content_length !== want.length)
            report($sformatf("content_length %0d, want %0d", out_ch.content_length,
                             want.length));
          if (out_ch.is_chunked !== want.chunked)
            report($sformatf("is_chunked %b, want %b", out_ch.is_chunked, want.chunked));
          if (out_ch.is_stream !== want.stream)
            report($sformatf("is_stream %b, want %b", out_ch.is_stream, want.stream));
          if (out_ch.redirect !== want.redirect)
            report($sformatf("redirect %b, want %b", out_ch.redirect, want.redirect));
        end
        results++;
      end
      if (out_gap > 0) begin
        out_gap--;
        drv_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 9);
        drv_ready <= 1'b0;
      end else begin
        drv_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("http_response_header_parser_core regression: fail");
      $finish;
    end
  end

  initial begin
    int    mark;
    int    pick;
    int    code;
    string txt;
    reset_parse();

    // good reply, length wrap, chunked, bytes after the end
    begin_reply();
    put_line("HTTP/1.1 200 OK");
    put_line("Content-Length: 4294967295");
    put_line("Content-Length: 4294967297");
    put_line("Transfer-Encoding: chunked");
    put_line("");
    put_text("junk");
    put(CH_LF);
    // redirect with tab and sign, bare LF endings, range
    begin_reply();
    drain_open = 1'b1;
    put_text("HTTP/1.1\t+302 Found");
    put(CH_LF);
    put_text("Location: \t/x");
    put(CH_LF);
    put_line("Content-Range: bytes 0-9/10");
    put(CH_LF);
    // error codes and their edges
    begin_reply();
    put_line("HTTP/1.0 404 Not Found");
    put_line("Location: /y");
    begin_reply();
    put_line("H 599");
    put_line("");
    begin_reply();
    put_line("H 600");
    put_line("");
    begin_reply();
    put_line("H 399");
    put_line("Location: /z");
    // saturation, minus sign, missing code
    begin_reply();
    put_line("H 123456");
    put_line("");
    begin_reply();
    put_line("H -302");
    put_line("Location: /m");
    begin_reply();
    put_line("HTTP/1.1");
    put_line("");
    begin_reply();
    put_line("H  x200");
    put_line("");
    // empty first line
    begin_reply();
    put(CH_CR);
    put(CH_LF);
    put(CH_LF);
    // tag matching and value forms
    begin_reply();
    put_line("H 200");
    put_line("location: /a");
    put_line("Locationx: /a");
    put_line("Location");
    put_line("Content-Length: 12ab3");
    put_line("Content-Length:");
    put_line("Transfer-Encoding: chunkedx");
    put_line("Transfer-Encoding: Chunked");
    put_line("Transfer-Encoding:chunked");
    put_text("Content-Length: 7");
    put(CH_CR);
    put_text("8");
    put(CH_CR);
    put(CH_LF);
    put_text("X-");
    put(8'h00);
    put_line(":v");
    put(CH_CR);
    put(CH_CR);
    put(CH_LF);
    // overlong lines: stored CR, then CR beyond the limit
    put_text("Location: ");
    repeat (LINE_LIMIT - 12) put("a");
    put(CH_CR);
    put_text("bb");
    put(CH_CR);
    put(CH_LF);
    put_line("");
    begin_reply();
    put_line("H 301");
    put_text("Location: ");
    repeat (LINE_LIMIT - 12) put("a");
    put(CH_CR);
    put(CH_LF);
    put_text("Content-Length: 77");
    repeat (LINE_LIMIT) put("z");
    put(CH_CR);
    put(CH_LF);
    put_line("");
    // restart in the middle of a reply
    begin_reply();
    put_text("HTTP/1.1 5");
    begin_reply();
    put_line("HTTP/1.1 204 No");
    put_line("");

    mark = byte_q.size();
    while (byte_q.size() - mark < 650) begin
      begin_reply();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 40))
          put(($urandom_range(0, 9) == 0) ? CH_LF : 8'($urandom_range(0, 255)));
      end else begin
        pick = $urandom_range(0, 13);
        if (pick < 12) code = code_pool[pick];
        else if (pick == 12) code = $urandom_range(0, 1999);
        else code = $urandom_range(0, 99999);
        put_text(($urandom_range(0, 1) == 1) ? "HTTP/1.1" : "HTTP/1.0");
        put(CH_SPACE);
        put_gap(1);
        case ($urandom_range(0, 9))
          0: put(CH_PLUS);
          1: put(CH_MINUS);
          default: ;
        endcase
        if ($urandom_range(0, 15) != 0) put_text($sformatf("%0d", code));
        put_text(" R");
        put_eol();
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 8))
            0: begin
              put_text("Location:");
              put_gap(2);
              put_text("/r");
            end
            1: begin
              put_text("Content-Length:");
              put_gap(2);
              case ($urandom_range(0, 3))
                0: put_text($sformatf("%0d", $urandom_range(0, 9999)));
                1: put_text($sformatf("%0d", $urandom));
                2: put_text($sformatf("%0d%0d", $urandom, $urandom));
                default: ;
              endcase
              if ($urandom_range(0, 3) == 0) put_text(" x");
            end
            2: begin
              put_text("Content-Range:");
              put_gap(2);
              put_text("bytes 0-99/100");
            end
            3: begin
              put_text("Transfer-Encoding:");
              put_gap(2);
              put_text("chunked");
            end
            4: begin
              put_text("Transfer-Encoding:");
              put_gap(2);
              case ($urandom_range(0, 3))
                0: put_text("gzip");
                1: put_text("chunked, gzip");
                2: put_mutated("chunked");
                default: put_text("chunke");
              endcase
            end
            5: put_text("Server: unit");
            6: begin
              put_mutated(tag_names[$urandom_range(0, NTAGS - 1)]);
              put_text(": 302");
            end
            7: begin
              txt = tag_names[$urandom_range(0, NTAGS - 1)];
              if ($urandom_range(0, 1) == 1) put_text(txt.substr(0, txt.len() - 2));
              else put_text(txt);
              put_text(($urandom_range(0, 1) == 1) ? ":1" : " 1");
            end
            default: repeat ($urandom_range(1, 20)) put(8'($urandom_range(0, 255)));
          endcase
          put_eol();
        end
        if ($urandom_range(0, 7) != 0) put_eol();
        if ($urandom_range(0, 3) == 0) put_text("tail");
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (byte_q.size() != 0 || status_due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("http_response_header_parser_core regression: pass");
    end else begin
      $display("http_response_header_parser_core regression: fail");
    end
    $finish;
  end

endmodule
